// File: design/tacm_pkg.sv
// Package for the two-axis min/max calibration and map block.
// Holds operation codes, output limits and the back-end status type.
// No dependencies.
`default_nettype none

package tacm_pkg;

  // Default sample width and queue depth.
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Operation codes carried in func.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_CAL   = 2'd1;
  localparam logic [1:0] FUNC_MAP   = 2'd2;

  // A sample equal to this value is not a real reading.
  localparam int INVALID_SAMPLE = 1;

  // Output range and span of the linear map.
  localparam logic signed [7:0] OUT_LO   = -8'sd127;
  localparam logic signed [7:0] OUT_HI   = 8'sd127;
  localparam int                MAP_SPAN = 254;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic busy;
    logic load;
  } back_stat_t;

endpackage

`default_nettype wire

// File: design/tacm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned magnitudes only; used by tacm_back. Depends on nothing.
`default_nettype none

module tacm_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quotient_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W+1:0] trial;

  // Trial subtract of the shifted remainder.
  assign trial = {1'b0, rem_q, quo_q[NUM_W-1]} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUM_W);
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!trial[DEN_W+1]) begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= busy_q && (cnt_q == CW'(1));
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: design/tacm_fifo.sv
// Small register queue between the front and back ends.
// Generic width and depth; depends on nothing.
`default_nettype none

module tacm_fifo #(
  parameter int WIDTH = 100,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == CW'(DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/tacm_front.sv
// Front end: accepts items, keeps per-axis min/max, queues map requests.
// Depends on tacm_pkg.
`default_nettype none

module tacm_front
  import tacm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic signed [SAMPLE_BITS-1:0] raw_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] raw_y_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output logic [4*(SAMPLE_BITS+1)-1:0]       push_data_o
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] INV_S = SAMPLE_BITS'(INVALID_SAMPLE);

  typedef struct packed {
    logic signed [DW-1:0] diff_x;
    logic signed [DW-1:0] den_x;
    logic signed [DW-1:0] diff_y;
    logic signed [DW-1:0] den_y;
  } map_req_t;

  logic signed [SAMPLE_BITS-1:0] low_x_q, low_x_d, high_x_q, high_x_d;
  logic signed [SAMPLE_BITS-1:0] low_y_q, low_y_d, high_y_q, high_y_d;
  logic     accept, x_ok, y_ok;
  map_req_t req;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign x_ok       = (raw_x_i != INV_S);
  assign y_ok       = (raw_y_i != INV_S);

  always_comb begin
    low_x_d  = low_x_q;
    high_x_d = high_x_q;
    low_y_d  = low_y_q;
    high_y_d = high_y_q;
    if (accept) begin
      case (func_i)
        FUNC_CLEAR: begin
          low_x_d  = SMAX;
          high_x_d = SMIN;
          low_y_d  = SMAX;
          high_y_d = SMIN;
        end
        FUNC_CAL: begin
          if (x_ok && (raw_x_i < low_x_q))  low_x_d  = raw_x_i;
          if (x_ok && (raw_x_i > high_x_q)) high_x_d = raw_x_i;
          if (y_ok && (raw_y_i < low_y_q))  low_y_d  = raw_y_i;
          if (y_ok && (raw_y_i > high_y_q)) high_y_d = raw_y_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_x_q  <= SMAX;
      high_x_q <= SMIN;
      low_y_q  <= SMAX;
      high_y_q <= SMIN;
    end else begin
      low_x_q  <= low_x_d;
      high_x_q <= high_x_d;
      low_y_q  <= low_y_d;
      high_y_q <= high_y_d;
    end
  end

  // Capture offsets against the range in force now, so later updates
  // do not disturb a queued request.
  always_comb begin
    req.diff_x = DW'(raw_x_i) - DW'(low_x_q);
    req.den_x  = DW'(high_x_q) - DW'(low_x_q);
    req.diff_y = DW'(raw_y_i) - DW'(low_y_q);
    req.den_y  = DW'(high_y_q) - DW'(low_y_q);
  end

  assign push_o      = accept && (func_i == FUNC_MAP) && x_ok && y_ok;
  assign push_data_o = req;

endmodule

`default_nettype wire

// File: design/tacm_back.sv
// Back end: scales, divides and clamps both axes, holds the result register.
// Depends on tacm_pkg and tacm_div.
`default_nettype none

module tacm_back
  import tacm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    pop_valid_i,
  output logic                         pop_ready_o,
  input  wire logic [4*(SAMPLE_BITS+1)-1:0] pop_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [7:0]            axis_x_o,
  output logic signed [7:0]            axis_y_o,
  output back_stat_t                   stat_o
);

  localparam int DW    = SAMPLE_BITS + 1;
  localparam int NUM_W = SAMPLE_BITS + 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  typedef struct packed {
    logic signed [DW-1:0] diff_x;
    logic signed [DW-1:0] den_x;
    logic signed [DW-1:0] diff_y;
    logic signed [DW-1:0] den_y;
  } map_req_t;

  map_req_t req;
  logic [1:0] st_q, st_d;
  logic       start, out_free, load, out_valid_q;
  logic signed [7:0] axis_x_q, axis_y_q;

  logic signed [DW-1:0]    diff_l [2];
  logic signed [DW-1:0]    den_l  [2];
  logic [SAMPLE_BITS-1:0]  mag_n  [2];
  logic [SAMPLE_BITS-1:0]  mag_d  [2];
  logic [NUM_W-1:0]        num_l  [2];
  logic [NUM_W-1:0]        quo_l  [2];
  logic                    done_l [2];
  logic                    neg_q  [2];
  logic                    zero_q [2];
  logic signed [7:0]       res_l  [2];

  assign req       = pop_data_i;
  assign diff_l[0] = req.diff_x;
  assign den_l[0]  = req.den_x;
  assign diff_l[1] = req.diff_y;
  assign den_l[1]  = req.den_y;

  assign pop_ready_o = (st_q == ST_IDLE);
  assign start       = pop_valid_i && pop_ready_o;

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic signed [DW-1:0] abs_n, abs_d;

    assign abs_n    = diff_l[i][DW-1] ? -diff_l[i] : diff_l[i];
    assign abs_d    = den_l[i][DW-1] ? -den_l[i] : den_l[i];
    assign mag_n[i] = abs_n[SAMPLE_BITS-1:0];
    assign mag_d[i] = abs_d[SAMPLE_BITS-1:0];
    // Scale by the output span: x*254 = x*256 - x*2.
    assign num_l[i] = (NUM_W'(mag_n[i]) << 8) - (NUM_W'(mag_n[i]) << 1);

    tacm_div #(
      .NUM_W(NUM_W),
      .DEN_W(SAMPLE_BITS)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (start),
      .dividend_i (num_l[i]),
      .divisor_i  (mag_d[i]),
      .done_o     (done_l[i]),
      .quotient_o (quo_l[i])
    );

    always_ff @(posedge clk_i) begin
      if (start) begin
        neg_q[i]  <= diff_l[i][DW-1] ^ den_l[i][DW-1];
        zero_q[i] <= (den_l[i] == '0);
      end
    end

    // A negative quotient, or an empty range, lands on the low limit.
    always_comb begin
      if (zero_q[i] || neg_q[i]) begin
        res_l[i] = OUT_LO;
      end else if (quo_l[i] > NUM_W'(MAP_SPAN)) begin
        res_l[i] = OUT_HI;
      end else begin
        res_l[i] = quo_l[i][7:0] - 8'(OUT_HI);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign load     = ((st_q == ST_RUN && done_l[0]) || st_q == ST_WAIT) && out_free;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (start) st_d = ST_RUN;
      ST_RUN: begin
        if (done_l[0]) st_d = out_free ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      axis_x_q <= res_l[0];
      axis_y_q <= res_l[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign axis_x_o    = axis_x_q;
  assign axis_y_o    = axis_y_q;
  assign stat_o.busy = (st_q != ST_IDLE);
  assign stat_o.load = load;

endmodule

`default_nettype wire

// File: design/two_axis_minmax_calibrate_map.sv
// Two-axis min/max calibration with linear map onto -127..127 and clamp.
// Clear and calibrate items update only the front end's min/max registers; a map item
// is queued and divided by the bit-serial divider of each axis. The back end takes a
// new map request only while idle, so it finishes one before taking the next.
// Reset returns both axes' min/max to their reset range and empties the queue;
// no clearing pass is needed.
`default_nettype none

module two_axis_minmax_calibrate_map
  import tacm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic signed [SAMPLE_BITS-1:0] raw_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] raw_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [7:0]                  axis_x_o,
  output logic signed [7:0]                  axis_y_o
);

  // One queue entry: offset and range width for each axis.
  localparam int ENTRY_W = 4 * (SAMPLE_BITS + 1);

  logic               push, full, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;
  back_stat_t         back_stat;

  // Front: take items, keep the calibration range, queue map requests.
  tacm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue: decouple classification from the slow divide.
  tacm_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Back: scale, divide, clamp and present the result.
  tacm_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .axis_x_o    (axis_x_o),
    .axis_y_o    (axis_y_o),
    .stat_o      (back_stat)
  );

  // Never overwrite a result that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !back_stat.load)
    else $error("result overwritten while stalled");

  // The clamp never lets the most negative code through.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (axis_x_o != 8'sh80) && (axis_y_o != 8'sh80))
    else $error("output outside -127..127");

  // The back end takes a new request only while idle.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |-> !back_stat.busy)
    else $error("request popped while back end busy");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for two_axis_minmax_calibrate_map: directed corner items, then
// random clear/calibrate/map sequences under random handshake idling and a long output hold.
// Depends on tacm_pkg and the two_axis_minmax_calibrate_map RTL only.
`timescale 1ns / 100ps

module testbench;
  import tacm_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int ITEM_GOAL    = 950;
  localparam int CALM_ITEMS   = 100;   // no idling on either side for the tail of the run
  localparam int HOLD_CYCLES  = 400;   // long output hold that backs up the input
  localparam int DRAIN_CYCLES = 60;    // margin after the last result to catch strays
  localparam int IDLE_LIMIT   = 3000;  // cycles without any handshake before giving up

  // Code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
  } axis_pair_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

  // Scoreboard: tracks per-axis min/max the way the block should, predicts the
  // mapped pair for every accepted map item and matches results in order.
  class minmax_scoreboard;
    sample_t    lo_x, hi_x, lo_y, hi_y;
    axis_pair_t expected_axes_q[$];
    int n_clear, n_cal, n_map, n_skip, n_ignored, n_results, n_clamped, n_errors;

    function void clear_range();
      lo_x = SAMPLE_MAX;
      hi_x = SAMPLE_MIN;
      lo_y = SAMPLE_MAX;
      hi_y = SAMPLE_MIN;
    endfunction

    // Linear map of [lo,hi] onto [-127,127] in 64 bits, truncating division, then clamp.
    function logic signed [7:0] map_axis(sample_t s, sample_t lo, sample_t hi);
      longint v;
      if (hi == lo) return OUT_LO;
      v = (longint'(s) - longint'(lo)) * MAP_SPAN / (longint'(hi) - longint'(lo)) + OUT_LO;
      if (v > OUT_HI) begin
        v = OUT_HI;
        n_clamped++;
      end else if (v < OUT_LO) begin
        v = OUT_LO;
        n_clamped++;
      end
      return v[7:0];
    endfunction

    function void note_item(logic [1:0] f, sample_t x, sample_t y);
      axis_pair_t p;
      case (f)
        FUNC_CLEAR: begin
          clear_range();
          n_clear++;
        end
        FUNC_CAL: begin
          // An invalid sample leaves only its own axis alone.
          if (x != INVALID_SAMPLE) begin
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
          end
          if (y != INVALID_SAMPLE) begin
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
          end
          n_cal++;
        end
        FUNC_MAP: begin
          if (x == INVALID_SAMPLE || y == INVALID_SAMPLE) begin
            n_skip++;
          end else begin
            p.x = map_axis(x, lo_x, hi_x);
            p.y = map_axis(y, lo_y, hi_y);
            expected_axes_q.push_back(p);
            n_map++;
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_axes(logic signed [7:0] ax, logic signed [7:0] ay);
      axis_pair_t w;
      n_results++;
      if (expected_axes_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: unexpected result x=%0d y=%0d at %0t", ax, ay, $realtime);
        return;
      end
      w = expected_axes_q.pop_front();
      if (ax !== w.x || ay !== w.y) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d at %0t",
                   w.x, w.y, ax, ay, $realtime);
      end
    endfunction

    function int pending();
      return expected_axes_q.size();
    endfunction
  endclass

  // Block ports; every input starts at a known value.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] func_i      = FUNC_CLEAR;
  sample_t    raw_x_i     = '0;
  sample_t    raw_y_i     = '0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic signed [7:0] axis_x_o;
  logic signed [7:0] axis_y_o;

  minmax_scoreboard sb = new;

  int items_sent = 0;   // accepted items other than the ignored code
  bit calm       = 0;   // tail of the run: no idling at all
  bit gaps_on    = 1;   // sender idling phase; alternates with idle-free stretches
  bit hold_req   = 0;   // sender asks the receiver for one long hold

  two_axis_minmax_calibrate_map #(
    .SAMPLE_BITS(SB)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .raw_x_i    (raw_x_i),
    .raw_y_i    (raw_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .axis_x_o   (axis_x_o),
    .axis_y_o   (axis_y_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Offer one item, hold it until accepted, log it, then maybe idle a short burst.
  // Valid is lowered only for an idle burst, so back-to-back items keep it high.
  task automatic send_item(input logic [1:0] f, input sample_t x, input sample_t y);
    in_valid_i <= 1'b1;
    func_i     <= f;
    raw_x_i    <= x;
    raw_y_i    <= y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(f, x, y);
    if (f != FUNC_UNUSED) items_sent++;
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Sample around a center; wraps at the 24-bit edges, which only widens the range.
  function automatic sample_t near(sample_t c, int spread);
    int off;
    off = $urandom_range(0, 2 * spread) - spread;
    return sample_t'(int'(c) + off);
  endfunction

  // Mostly a sample near the center, now and then the invalid marker.
  function automatic sample_t pick(sample_t c, int spread);
    if ($urandom_range(0, 19) == 0) return sample_t'(INVALID_SAMPLE);
    return near(c, spread);
  endfunction

  function automatic sample_t noise_sample();
    case ($urandom_range(0, 7))
      0:       return sample_t'(INVALID_SAMPLE);
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_MAX;
      3:       return near('0, 32);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // A well-formed pass: clear (usually), calibrate a few pairs around random
  // centers, then map pairs drawn from a slightly wider window so some clamp.
  task automatic play_sequence();
    sample_t cx, cy;
    int      spx, spy;
    cx  = sample_t'($urandom());
    cy  = sample_t'($urandom());
    spx = $urandom_range(0, 1 << $urandom_range(0, 22));
    spy = $urandom_range(0, 1 << $urandom_range(0, 22));
    // Zero spread gives equal min and max after calibration.
    if ($urandom_range(0, 9) == 0) spx = 0;
    if ($urandom_range(0, 9) == 0) spy = 0;
    if ($urandom_range(0, 6) != 0) send_item(FUNC_CLEAR, noise_sample(), noise_sample());
    repeat ($urandom_range(1, 6)) send_item(FUNC_CAL, pick(cx, spx), pick(cy, spy));
    repeat ($urandom_range(2, 8))
      send_item(FUNC_MAP, pick(cx, spx + spx / 4 + 2), pick(cy, spy + spy / 4 + 2));
  endtask

  // Output side: check every accepted result, then pick next cycle's ready.
  // Handshakes are judged on the values present before this edge.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_axes(axis_x_o, axis_y_o);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && (sb.n_results / 50) % 3 != 1 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: give up once no handshake has happened on either side for too long.
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_run = 0;
      else idle_run++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    bit pressure_done;
    pressure_done = 0;
    sb.clear_range();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Map straight out of reset: min above max is used as is.
    send_item(FUNC_MAP, sample_t'(100), sample_t'(-100));
    send_item(FUNC_MAP, SAMPLE_MIN, SAMPLE_MAX);
    // Invalid sample in calibrate skips only its own axis.
    send_item(FUNC_CAL, sample_t'(INVALID_SAMPLE), sample_t'(500));
    // Invalid sample on either axis suppresses the map result.
    send_item(FUNC_MAP, sample_t'(300), sample_t'(INVALID_SAMPLE));
    send_item(FUNC_MAP, sample_t'(INVALID_SAMPLE), sample_t'(200));
    send_item(FUNC_CAL, sample_t'(-1000), sample_t'(INVALID_SAMPLE));
    // Single-point ranges on both axes: equal min and max.
    send_item(FUNC_MAP, sample_t'(-1000), sample_t'(500));
    // Unused code must change nothing.
    send_item(FUNC_UNUSED, sample_t'(1234), sample_t'(5678));
    send_item(FUNC_CAL, sample_t'(1000), sample_t'(-500));
    send_item(FUNC_MAP, sample_t'(0), sample_t'(0));
    send_item(FUNC_MAP, sample_t'(-2000), sample_t'(2000));
    send_item(FUNC_MAP, sample_t'(1000), sample_t'(-500));
    send_item(FUNC_MAP, sample_t'(-1000), sample_t'(500));
    // Full-scale range, samples at both extremes.
    send_item(FUNC_CLEAR, SAMPLE_MAX, SAMPLE_MIN);
    send_item(FUNC_CAL, SAMPLE_MIN, SAMPLE_MIN);
    send_item(FUNC_CAL, SAMPLE_MAX, SAMPLE_MAX);
    send_item(FUNC_MAP, SAMPLE_MIN, SAMPLE_MAX);
    send_item(FUNC_MAP, SAMPLE_MAX, SAMPLE_MIN);
    send_item(FUNC_MAP, sample_t'(0), sample_t'(-1));
    send_item(FUNC_MAP, sample_t'(2), sample_t'(0));
    send_item(FUNC_UNUSED, SAMPLE_MAX, SAMPLE_MIN);
    send_item(FUNC_CLEAR, '0, '0);
    send_item(FUNC_MAP, sample_t'(-1), SAMPLE_MAX);

    // Random part: mostly well-formed sequences, some loose noise items.
    while (items_sent < ITEM_GOAL) begin
      calm    = items_sent > ITEM_GOAL - CALM_ITEMS;
      gaps_on = ((items_sent / 70) % 3) != 2;
      if (!pressure_done && items_sent > 300) begin
        // Hold the output and keep feeding maps until the input stalls.
        pressure_done = 1;
        hold_req      = 1;
        repeat (12)
          send_item(FUNC_MAP, sample_t'($urandom_range(2, 5000)),
                    sample_t'(-$urandom_range(0, 5000)));
      end else if ($urandom_range(0, 9) == 0) begin
        send_item(2'($urandom_range(0, 3)), noise_sample(), noise_sample());
      end else begin
        play_sequence();
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then idle long enough to catch strays.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d items: %0d clears, %0d calibrations, %0d maps, %0d ignored codes.",
             items_sent, sb.n_clear, sb.n_cal, sb.n_map + sb.n_skip, sb.n_ignored);
    $display("Checked %0d results (%0d clamped axes), %0d maps dropped as invalid, %0d errors.",
             sb.n_results, sb.n_clamped, sb.n_skip, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/tacm_pkg.sv
design/tacm_div.sv
design/tacm_fifo.sv
design/tacm_front.sv
design/tacm_back.sv
design/two_axis_minmax_calibrate_map.sv
tb/testbench.sv
